>>> design/rspg_pkg.sv
// Shared types, constants and GF(256) arithmetic for the RS parity generator.
// No dependencies; used by rspg_gen_derive and rs_parity_generator_gf256_core.
`default_nettype none

package rspg_pkg;

    localparam int DATA_W       = 8;
    localparam int CFG_W        = 6;
    localparam int MIN_DEGREE   = 2;
    localparam int RESET_DEGREE = 10;

    // Low byte of the field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [DATA_W-1:0] GF_POLY_LOW = 8'h1D;
    localparam logic [DATA_W-1:0] GF_ONE      = 8'h01;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              block_end;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] parity_byte;
        logic              parity_last;
    } t_out_item;

    // Multiply by alpha (x) modulo the field polynomial
    function automatic logic [DATA_W-1:0] gf_xtime(input logic [DATA_W-1:0] a);
        gf_xtime = {a[DATA_W-2:0], 1'b0} ^ (a[DATA_W-1] ? GF_POLY_LOW : '0);
    endfunction

    // Full GF(256) multiply, MSB-first shift and add over the bits of b
    function automatic logic [DATA_W-1:0] gf_mul(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int bit_idx = DATA_W - 1; bit_idx >= 0; bit_idx--) begin
            acc = gf_xtime(acc);
            acc = acc ^ (b[bit_idx] ? a : '0);
        end
        gf_mul = acc;
    endfunction

endpackage

`default_nettype wire

>>> design/rspg_gen_derive.sv
// Iterative derivation of the monic RS generator polynomial, one root per cycle.
// Depends on rspg_pkg (gf_mul, gf_xtime, constants).
`default_nettype none

module rspg_gen_derive #(
    parameter int MAX_DEGREE = 32,
    parameter int DW         = 6
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_start,
    input  wire logic [DW-1:0]                               i_degree,
    output logic                                             o_busy,
    output logic [MAX_DEGREE-1:0][rspg_pkg::DATA_W-1:0]      o_coeffs
);

    logic [MAX_DEGREE-1:0][rspg_pkg::DATA_W-1:0] r_coeffs;
    logic [MAX_DEGREE-1:0][rspg_pkg::DATA_W-1:0] n_coeffs_init;
    logic [MAX_DEGREE-1:0][rspg_pkg::DATA_W-1:0] n_coeffs_step;
    logic [rspg_pkg::DATA_W-1:0]                 r_root;
    logic [DW-1:0]                               r_iter;
    logic                                        r_busy;

    // Start value: only the leading stored coefficient is one
    // One root step: c[j] = c[j]*root + c[j+1] over the active taps
    for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_tap
        logic [rspg_pkg::DATA_W-1:0] upper;
        if (j + 1 < MAX_DEGREE) begin : g_upper
            assign upper = (DW'(j + 1) < i_degree) ? r_coeffs[j+1] : '0;
        end else begin : g_top
            assign upper = '0;
        end
        assign n_coeffs_init[j] = (DW'(j + 1) == i_degree) ? rspg_pkg::GF_ONE : '0;
        assign n_coeffs_step[j] = (DW'(j) < i_degree)
                                ? (rspg_pkg::gf_mul(r_coeffs[j], r_root) ^ upper)
                                : r_coeffs[j];
    end

    // Sequence control: load on start, one root per cycle until degree roots done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            if (r_iter == i_degree - DW'(1)) begin
                r_busy <= 1'b0;
            end
            r_iter <= r_iter + DW'(1);
        end
    end

    // Coefficient store and running root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_coeffs <= n_coeffs_init;
            r_root   <= rspg_pkg::GF_ONE;
        end else if (r_busy) begin
            r_coeffs <= n_coeffs_step;
            r_root   <= rspg_pkg::gf_xtime(r_root);
        end
    end

    assign o_busy   = r_busy;
    assign o_coeffs = r_coeffs;

endmodule

`default_nettype wire

>>> design/rs_parity_generator_gf256_core.sv
// Reset: synchronous, active low. After reset, and after every degree write,
// the generator is re-derived with the input stalled.
// Latency: parity of a block starts the cycle after its last byte transfers.
// Throughput: one data byte per cycle when not stalled, set by the parallel
// LFSR tap update; each block drains degree parity bytes from a shift buffer,
// one per cycle unless stalled; a block end byte also waits on the prior drain.
`default_nettype none

module rs_parity_generator_gf256_core #(
    parameter int MAX_DEGREE = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // data byte channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire rspg_pkg::t_in_item             i_in_data,
    // parity byte channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output rspg_pkg::t_out_item                 o_out_data,
    // degree register write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rspg_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int CMP_W = (DW > rspg_pkg::CFG_W) ? DW : rspg_pkg::CFG_W;
    localparam int DEG_RST = (rspg_pkg::RESET_DEGREE > MAX_DEGREE)
                           ? MAX_DEGREE : rspg_pkg::RESET_DEGREE;
    localparam int BW = rspg_pkg::DATA_W;

    logic [DW-1:0]                  r_degree;
    logic [DW-1:0]                  n_degree;
    logic                           r_gen_start;
    logic                           gen_busy;
    logic [MAX_DEGREE-1:0][BW-1:0]  gen_coeffs;
    logic [MAX_DEGREE-1:0][BW-1:0]  r_rem;
    logic [MAX_DEGREE-1:0][BW-1:0]  n_rem;
    logic [MAX_DEGREE-1:0][BW-1:0]  r_par;
    logic [DW-1:0]                  r_emit_cnt;
    logic [BW-1:0]                  feedback;
    logic [CMP_W-1:0]               cfg_wide;
    logic                           cfg_xfer;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           emit_free;

    // Generator polynomial sequencer
    rspg_gen_derive #(
        .MAX_DEGREE (MAX_DEGREE),
        .DW         (DW)
    ) u_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_gen_start),
        .i_degree (r_degree),
        .o_busy   (gen_busy),
        .o_coeffs (gen_coeffs)
    );

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign emit_free   = (r_emit_cnt == '0) || ((r_emit_cnt == DW'(1)) && out_xfer);
    assign o_in_stall  = r_gen_start || gen_busy || (i_in_data.block_end && !emit_free);
    assign in_xfer     = i_in_valid && !o_in_stall;

    // Saturate the written degree into the supported range
    always_comb begin
        cfg_wide = CMP_W'(i_cfg_data);
        if (cfg_wide < CMP_W'(rspg_pkg::MIN_DEGREE)) begin
            n_degree = DW'(rspg_pkg::MIN_DEGREE);
        end else if (cfg_wide > CMP_W'(MAX_DEGREE)) begin
            n_degree = DW'(MAX_DEGREE);
        end else begin
            n_degree = DW'(cfg_wide);
        end
    end

    // LFSR division step: shift toward the head, add coeff times feedback
    assign feedback = i_in_data.data_byte ^ r_rem[0];
    for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_lfsr
        logic [BW-1:0] shifted;
        if (i + 1 < MAX_DEGREE) begin : g_shift
            assign shifted = (DW'(i + 1) < r_degree) ? r_rem[i+1] : '0;
        end else begin : g_tail
            assign shifted = '0;
        end
        assign n_rem[i] = (DW'(i) < r_degree)
                        ? (shifted ^ rspg_pkg::gf_mul(gen_coeffs[i], feedback))
                        : '0;
    end

    // Degree register and derivation trigger
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree    <= DW'(DEG_RST);
            r_gen_start <= 1'b1;
        end else begin
            r_gen_start <= cfg_xfer;
            if (cfg_xfer) begin
                r_degree <= n_degree;
            end
        end
    end

    // Remainder: advance on each data transfer, drop at block end or degree write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (cfg_xfer) begin
            r_rem <= '0;
        end else if (in_xfer) begin
            r_rem <= i_in_data.block_end ? '0 : n_rem;
        end
    end

    // Parity drain counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_cnt <= '0;
        end else if (cfg_xfer) begin
            r_emit_cnt <= '0;
        end else if (in_xfer && i_in_data.block_end) begin
            r_emit_cnt <= r_degree;
        end else if (out_xfer) begin
            r_emit_cnt <= r_emit_cnt - DW'(1);
        end
    end

    // Parity shift buffer: load the final remainder, shift out head first
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.block_end) begin
            r_par <= n_rem;
        end else if (out_xfer) begin
            r_par <= {BW'(0), r_par[MAX_DEGREE-1:1]};
        end
    end

    assign o_out_valid             = (r_emit_cnt != '0);
    assign o_out_data.parity_byte  = r_par[0];
    assign o_out_data.parity_last  = (r_emit_cnt == DW'(1));

    // No parity leaves while the generator is being derived
    a_no_out_during_derive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_busy |-> !o_out_valid)
        else $error("parity output valid during generator derivation");

    // Drain count never exceeds the active degree
    a_emit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= r_degree)
        else $error("parity drain count above degree");

    // A block end loads a full set of parity bytes
    a_block_end_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.block_end && !cfg_xfer) |=> (r_emit_cnt == r_degree))
        else $error("block end did not load the parity buffer");

    // After the final parity byte the buffer is empty or holds a fresh block
    a_last_then_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.parity_last && !cfg_xfer)
            |=> (!o_out_valid || (r_emit_cnt == r_degree)))
        else $error("parity drain overran block boundary");

    // Degree stays within the supported range
    a_degree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_degree >= DW'(rspg_pkg::MIN_DEGREE)) && (r_degree <= DW'(MAX_DEGREE)))
        else $error("active degree out of range");

endmodule

`default_nettype wire
